// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the ready table scheduler.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clock, rstn, prop) \
	label: assert property (@(posedge clock) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clock, rstn, prop)
`define ASSERT_NEXT(label, clock, rstn, ante, cons)
`endif
`endif

// ----- src/prts_pkg.sv -----
// Shared constants of the process ready table scheduler: action and
// status codes and fixed field widths. No dependencies.
package prts_pkg;
	localparam int ACT_W  = 4;
	localparam int PID_W  = 8;
	localparam int AMT_W  = 32;
	localparam int STAT_W = 2;
	localparam int CHID_W = 8;
	localparam int LEFT_W = 32;

	localparam logic [ACT_W-1:0] ACT_ADD   = 4'd0;
	localparam logic [ACT_W-1:0] ACT_RR    = 4'd1;
	localparam logic [ACT_W-1:0] ACT_CONS  = 4'd2;
	localparam logic [ACT_W-1:0] ACT_RM    = 4'd3;
	localparam logic [ACT_W-1:0] ACT_SETW  = 4'd4;
	localparam logic [ACT_W-1:0] ACT_HRN   = 4'd5;
	localparam logic [ACT_W-1:0] ACT_SUP   = 4'd6;
	localparam logic [ACT_W-1:0] ACT_SDN   = 4'd7;
	localparam logic [ACT_W-1:0] ACT_READ  = 4'd8;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;
endpackage

// ----- src/process_ready_table_scheduler.sv -----
// Process ready table scheduler: table memory, sequencer, HRN divider.
// Depends on prts_pkg and assert_macros.svh.
//
// One request at a time. The table lives in a single memory with a registered
// read port; every table read passes a wait state between address and data.
// Add, error cases and unused codes answer at once; consume, set wait and
// read do a full id search; consume and set wait then do a read-modify-write;
// remove searches, then moves each later slot down by one; round robin
// reads the next entry; HRN divides each entry with nonzero work in the 32-step
// shift-subtract divider; the sorts do a selection scan through the memory
// port. A result waits in an output register, so the next request is taken
// while it is still pending. No clearing pass follows reset.
`include "assert_macros.svh"
module process_ready_table_scheduler #(
	parameter int ENTRIES   = 32,
	parameter int WORK_BITS = 32,
	parameter int ID_BITS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // proc_id[7:0], amount[39:8]
	input  logic [3:0]  s_axis_tuser,  // action[3:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // status[1:0], chosen_id[9:2], work_left[41:10],
	                                   // finished[42], zero[47:43]
);
	import prts_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CW    = (WORK_BITS > AMT_W) ? WORK_BITS : AMT_W;
	localparam int IW    = (ID_BITS > PID_W) ? ID_BITS : PID_W;
	localparam int QW    = AMT_W;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_WAIT    = 5'd1;
	localparam logic [4:0] S_RR_ID   = 5'd2;
	localparam logic [4:0] S_HRN_LD  = 5'd3;
	localparam logic [4:0] S_HRN_DIV = 5'd4;
	localparam logic [4:0] S_HRN_CMP = 5'd5;
	localparam logic [4:0] S_SORT_I  = 5'd6;
	localparam logic [4:0] S_SORT_LI = 5'd7;
	localparam logic [4:0] S_SORT_J  = 5'd8;
	localparam logic [4:0] S_SORT_W1 = 5'd9;
	localparam logic [4:0] S_SORT_W2 = 5'd10;
	localparam logic [4:0] S_FIND    = 5'd11;
	localparam logic [4:0] S_CONS    = 5'd12;
	localparam logic [4:0] S_SETW    = 5'd13;
	localparam logic [4:0] S_RDW     = 5'd14;
	localparam logic [4:0] S_RM      = 5'd15;
	localparam logic [4:0] S_RM_WR   = 5'd16;
	localparam logic [4:0] S_OUT     = 5'd17;

	typedef struct packed {
		logic [ID_BITS-1:0]   id;
		logic [WORK_BITS-1:0] work;
		logic [AMT_W-1:0]     wtime;
	} row_t;

	// table memory
	row_t mem [ENTRIES];
	row_t rdata;
	logic mem_we;
	logic [IDX_W-1:0] mem_wa;
	row_t mem_wd;

	// control
	logic [4:0] state_q, ret_q;
	logic [CNT_W-1:0] count_q, i_q, j_q, best_idx_q;
	logic [IDX_W-1:0] idx_q, cur_q, first_q, last_q, pick_q;
	logic rr_valid_q, found_q, zero_q, m_valid_q;
	logic [ID_BITS-1:0] next_id_q;

	// request and working registers
	logic [ACT_W-1:0] act_q;
	logic [PID_W-1:0] pid_q;
	logic [AMT_W-1:0] amt_q;
	row_t row_i_q, best_row_q;
	logic [QW:0] best_q;
	logic [WORK_BITS-1:0] div_q, rem_q;
	logic [QW-1:0] quo_q;
	logic [4:0] dcnt_q;

	// pending result and output register
	logic [STAT_W-1:0] res_st_q;
	logic [CHID_W-1:0] res_id_q;
	logic [LEFT_W-1:0] res_left_q;
	logic res_fin_q;
	logic [47:0] m_data_q;

	logic [ACT_W-1:0] act_in;
	logic s_fire, out_load;
	assign act_in = s_axis_tuser;
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

	// early status of an incoming request
	logic add_ok;
	logic [STAT_W-1:0] st_in;
	assign add_ok = (act_in == ACT_ADD) && (count_q < CNT_W'(ENTRIES));
	always_comb begin
		if (act_in > ACT_READ) begin
			st_in = ST_OK;
		end else if (act_in == ACT_ADD) begin
			st_in = add_ok ? ST_OK : ST_FULL;
		end else if (count_q == '0) begin
			st_in = ST_EMPTY;
		end else begin
			st_in = ST_OK;
		end
	end

	// id search on the row just read
	logic match, found_n;
	logic [IDX_W-1:0] first_n, last_n;
	assign match = (IW'(rdata.id) == IW'(pid_q));
	assign found_n = found_q || match;
	assign first_n = (found_q || !match) ? first_q : j_q[IDX_W-1:0];
	assign last_n = match ? j_q[IDX_W-1:0] : last_q;

	// divider step
	logic [WORK_BITS:0] trial;
	logic ge;
	assign trial = {rem_q, quo_q[QW-1]};
	assign ge = (trial >= {1'b0, div_q});

	// hrn ratio of the entry just divided
	logic [QW:0] ratio;
	logic better_hrn;
	assign ratio = zero_q ? (QW+1)'(1) : ({1'b0, quo_q} + (QW+1)'(1));
	assign better_hrn = (ratio > best_q);

	// sort compare
	logic better_srt;
	always_comb begin
		if (act_q == ACT_SUP) begin
			better_srt = (rdata.work < best_row_q.work);
		end else begin
			better_srt = (rdata.work > best_row_q.work);
		end
	end

	// saturating consume
	logic [CW-1:0] w_e, a_e;
	logic [WORK_BITS-1:0] nw;
	assign w_e = CW'(rdata.work);
	assign a_e = CW'(amt_q);
	assign nw = (w_e > a_e) ? WORK_BITS'(w_e - a_e) : '0;

	// round robin next cursor
	logic [CNT_W-1:0] cur_inc, rr_next;
	assign cur_inc = CNT_W'(cur_q) + CNT_W'(1);
	assign rr_next = (!rr_valid_q || cur_inc >= count_q) ? '0 : cur_inc;

	// memory write select
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = rdata;
		case (state_q)
			S_IDLE: begin
				if (s_fire && add_ok) begin
					mem_we = 1'b1;
					mem_wa = count_q[IDX_W-1:0];
					mem_wd = '{id: next_id_q, work: WORK_BITS'(s_axis_tdata[39:8]),
						wtime: '0};
				end
			end
			S_CONS: begin
				mem_we = 1'b1;
				mem_wd = '{id: rdata.id, work: nw, wtime: rdata.wtime};
			end
			S_SETW: begin
				mem_we = 1'b1;
				mem_wd = '{id: rdata.id, work: rdata.work, wtime: amt_q};
			end
			S_RM_WR: begin
				mem_we = 1'b1;
				mem_wa = j_q[IDX_W-1:0];
			end
			S_SORT_W1: begin
				mem_we = 1'b1;
				mem_wa = i_q[IDX_W-1:0];
				mem_wd = best_row_q;
			end
			S_SORT_W2: begin
				mem_we = 1'b1;
				mem_wa = best_idx_q[IDX_W-1:0];
				mem_wd = row_i_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata <= mem[idx_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			count_q    <= '0;
			rr_valid_q <= 1'b0;
			cur_q      <= '0;
			next_id_q  <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready && !out_load) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						act_q      <= act_in;
						pid_q      <= s_axis_tdata[7:0];
						amt_q      <= s_axis_tdata[39:8];
						res_st_q   <= st_in;
						res_id_q   <= add_ok ? CHID_W'(next_id_q) : '0;
						res_left_q <= '0;
						res_fin_q  <= 1'b0;
						// unused codes, adds and an empty table answer at once
						if (act_in > ACT_READ || act_in == ACT_ADD || count_q == '0) begin
							state_q <= S_OUT;
							if (add_ok) begin
								count_q   <= count_q + CNT_W'(1);
								next_id_q <= next_id_q + ID_BITS'(1);
							end
						end else if (act_in == ACT_RR) begin
							cur_q      <= rr_next[IDX_W-1:0];
							rr_valid_q <= 1'b1;
							idx_q      <= rr_next[IDX_W-1:0];
							ret_q      <= S_RR_ID;
							state_q    <= S_WAIT;
						end else if (act_in == ACT_HRN) begin
							j_q     <= '0;
							idx_q   <= '0;
							best_q  <= '0;
							pick_q  <= '0;
							ret_q   <= S_HRN_LD;
							state_q <= S_WAIT;
						end else if (act_in == ACT_SUP || act_in == ACT_SDN) begin
							i_q     <= '0;
							state_q <= S_SORT_I;
						end else begin
							j_q     <= '0;
							idx_q   <= '0;
							found_q <= 1'b0;
							ret_q   <= S_FIND;
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					state_q <= ret_q;
				end
				S_RR_ID: begin
					res_id_q <= CHID_W'(rdata.id);
					state_q  <= S_OUT;
				end
				S_HRN_LD: begin
					div_q  <= rdata.work;
					quo_q  <= rdata.wtime;
					rem_q  <= '0;
					dcnt_q <= '0;
					zero_q <= (rdata.work == '0);
					state_q <= (rdata.work == '0) ? S_HRN_CMP : S_HRN_DIV;
				end
				S_HRN_DIV: begin
					rem_q  <= ge ? WORK_BITS'(trial - {1'b0, div_q}) : WORK_BITS'(trial);
					quo_q  <= {quo_q[QW-2:0], ge};
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'(QW - 1)) begin
						state_q <= S_HRN_CMP;
					end
				end
				S_HRN_CMP: begin
					if (better_hrn) begin
						best_q <= ratio;
						pick_q <= j_q[IDX_W-1:0];
					end
					if (j_q + CNT_W'(1) < count_q) begin
						j_q   <= j_q + CNT_W'(1);
						idx_q <= IDX_W'(j_q + CNT_W'(1));
						ret_q <= S_HRN_LD;
					end else begin
						idx_q <= better_hrn ? j_q[IDX_W-1:0] : pick_q;
						ret_q <= S_RR_ID;
					end
					state_q <= S_WAIT;
				end
				S_SORT_I: begin
					if (i_q + CNT_W'(1) >= count_q) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= i_q[IDX_W-1:0];
						ret_q   <= S_SORT_LI;
						state_q <= S_WAIT;
					end
				end
				S_SORT_LI: begin
					row_i_q    <= rdata;
					best_row_q <= rdata;
					best_idx_q <= i_q;
					j_q        <= i_q + CNT_W'(1);
					idx_q      <= IDX_W'(i_q + CNT_W'(1));
					ret_q      <= S_SORT_J;
					state_q    <= S_WAIT;
				end
				S_SORT_J: begin
					if (better_srt) begin
						best_row_q <= rdata;
						best_idx_q <= j_q;
					end
					if (j_q + CNT_W'(1) < count_q) begin
						j_q     <= j_q + CNT_W'(1);
						idx_q   <= IDX_W'(j_q + CNT_W'(1));
						ret_q   <= S_SORT_J;
						state_q <= S_WAIT;
					end else if (better_srt || best_idx_q != i_q) begin
						state_q <= S_SORT_W1;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_SORT_I;
					end
				end
				S_SORT_W1: begin
					state_q <= S_SORT_W2;
				end
				S_SORT_W2: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= S_SORT_I;
				end
				S_FIND: begin
					found_q <= found_n;
					first_q <= first_n;
					last_q  <= last_n;
					if (j_q + CNT_W'(1) < count_q) begin
						j_q     <= j_q + CNT_W'(1);
						idx_q   <= IDX_W'(j_q + CNT_W'(1));
						state_q <= S_WAIT;
					end else if (!found_n) begin
						res_st_q <= ST_NOTFOUND;
						state_q  <= S_OUT;
					end else if (act_q == ACT_RM) begin
						// cursor dropped together with the count
						j_q        <= CNT_W'(first_n);
						count_q    <= count_q - CNT_W'(1);
						rr_valid_q <= 1'b0;
						cur_q      <= '0;
						state_q    <= S_RM;
					end else begin
						idx_q   <= last_n;
						state_q <= S_WAIT;
						case (act_q)
							ACT_CONS: ret_q <= S_CONS;
							ACT_SETW: ret_q <= S_SETW;
							default:  ret_q <= S_RDW;
						endcase
					end
				end
				S_CONS: begin
					res_left_q <= LEFT_W'(nw);
					res_fin_q  <= (nw == '0);
					state_q    <= S_OUT;
				end
				S_SETW: begin
					state_q <= S_OUT;
				end
				S_RDW: begin
					res_left_q <= LEFT_W'(rdata.work);
					state_q    <= S_OUT;
				end
				// count_q already holds the reduced count here
				S_RM: begin
					if (j_q < count_q) begin
						idx_q   <= IDX_W'(j_q + CNT_W'(1));
						ret_q   <= S_RM_WR;
						state_q <= S_WAIT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_RM_WR: begin
					j_q     <= j_q + CNT_W'(1);
					state_q <= S_RM;
				end
				S_OUT: begin
					if (out_load) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {5'd0, res_fin_q, res_left_q, res_id_q, res_st_q};
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(ENTRIES))
	`ASSERT_ALWAYS(a_cursor_in_table, clk, arst_n, !rr_valid_q || CNT_W'(cur_q) < count_q)
	`ASSERT_NEXT(a_add_grows, clk, arst_n,
		s_fire && act_in == ACT_ADD && count_q < CNT_W'(ENTRIES),
		count_q == $past(count_q) + CNT_W'(1))
	`ASSERT_NEXT(a_result_loaded, clk, arst_n, out_load, m_valid_q && state_q == S_IDLE)
endmodule
